// ----- rtl/l2h_pkg.sv -----
package l2h_pkg;

  localparam int unsigned MaxSlotDef  = 30;
  localparam int unsigned NumHooksDef = 8;

  localparam logic [62:0] OffsetReset = 63'd37000000000;

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_READ   = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [2:0]         hook_id;
    logic signed [63:0] stamp_ns;
    logic [62:0]        now_tai_ns;
    logic [4:0]         read_slot;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [4:0]  bucket_index;
    logic [62:0] latency_ns;
    logic [63:0] read_value;
  } rsp_t;

endpackage

// ----- rtl/log2_latency_histogram.sv -----
// log2 latency histogram with one 64-bit counter memory
//
// input channel in_valid_i / in_ready_o carries a record or a read item;
// output channel out_valid_o / out_ready_i returns one result per item.
// cfg_we_i writes the tai offset register at once; write it only while idle.
//
// one item is in flight at a time; the read-modify-write sequence on the
// counter memory (one read port, one write port) sets the states: a record
// runs calc, bin, cnt, sum (skipped at zero latency), out; a read runs
// rval, out; rejects skip to out. idle follows once the result is loaded.
//
// after reset the block sweeps the counter memory to zero, one entry per
// cycle over all NUM_HOOKS * (MAX_SLOT + 2) entries (256 at the defaults),
// with in_ready_o low. the offset register returns to its reset value.
//
// the result sits in an output register; while the receiver stalls it
// holds, and the block finishes the next item up to the point of loading
// it, then waits.
module log2_latency_histogram #(
  parameter int unsigned MAX_SLOT  = l2h_pkg::MaxSlotDef,
  parameter int unsigned NUM_HOOKS = l2h_pkg::NumHooksDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [62:0]   cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  l2h_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output l2h_pkg::rsp_t out_rsp_o
);
  import l2h_pkg::*;

  localparam int unsigned SlotsPerHook = MAX_SLOT + 2;
  localparam int unsigned Depth        = NUM_HOOKS * SlotsPerHook;
  localparam int unsigned AW           = $clog2(Depth);
  localparam int unsigned BW           = $clog2(MAX_SLOT + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_BIN,
    S_CNT,
    S_SUM,
    S_RVAL,
    S_OUT
  } state_e;

  state_e      state_q;
  logic [AW-1:0] clr_cnt_q;
  logic [62:0] offset_q;
  logic        out_valid_q;
  rsp_t        out_q;

  req_t          item_q;
  logic [63:0]   now_q;
  logic [62:0]   lat_q;
  logic [AW-1:0] base_q;
  logic [AW-1:0] cnt_addr_q;
  logic [BW-1:0] bucket_q;
  rsp_t          res_q;
  logic [63:0]   rdata_q;

  logic [63:0] mem [Depth];

  logic          in_xfer;
  logic          hook_ok;
  logic          slot_ok;
  logic [AW-1:0] in_base;
  logic [64:0]   diff;
  logic          stamp_ok;
  logic [BW-1:0] bucket;
  logic [AW-1:0] sum_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic          out_free;

  l2h_bucket #(
    .MAX_SLOT(MAX_SLOT),
    .BW      (BW)
  ) u_bucket (
    .latency_i(lat_q),
    .bucket_o (bucket)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign hook_ok  = 32'(in_req_i.hook_id) < NUM_HOOKS;
  assign slot_ok  = 32'(in_req_i.read_slot) <= (MAX_SLOT + 1);
  assign in_base  = AW'(32'(in_req_i.hook_id) * SlotsPerHook);
  assign sum_addr = base_q + AW'(MAX_SLOT + 1);

  assign diff     = {now_q[63], now_q} - {item_q.stamp_ns[63], item_q.stamp_ns};
  assign stamp_ok = !item_q.stamp_ns[63] && (item_q.stamp_ns != 64'sd0) && !diff[64];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = cnt_addr_q;
    wr_data = rdata_q + 64'd1;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        wr_data = '0;
      end
      S_IDLE: begin
        rd_en   = in_xfer && (in_req_i.req_type == REQ_READ) && hook_ok && slot_ok;
        rd_addr = in_base + AW'(in_req_i.read_slot);
      end
      S_BIN: begin
        rd_en   = 1'b1;
        rd_addr = base_q + AW'(bucket);
      end
      S_CNT: begin
        wr_en   = 1'b1;
        rd_en   = (lat_q != '0);
        rd_addr = sum_addr;
      end
      S_SUM: begin
        wr_en   = 1'b1;
        wr_addr = sum_addr;
        wr_data = rdata_q + {1'b0, lat_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      offset_q    <= OffsetReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(Depth - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            if (!hook_ok) begin
              state_q <= S_OUT;
            end else if (in_req_i.req_type == REQ_READ) begin
              state_q <= slot_ok ? S_RVAL : S_OUT;
            end else begin
              state_q <= S_CALC;
            end
          end
        end
        S_CALC: state_q <= stamp_ok ? S_BIN : S_OUT;
        S_BIN:  state_q <= S_CNT;
        S_CNT:  state_q <= (lat_q != '0) ? S_SUM : S_OUT;
        S_SUM:  state_q <= S_OUT;
        S_RVAL: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          item_q <= in_req_i;
          now_q  <= {1'b0, in_req_i.now_tai_ns} - {1'b0, offset_q};
          base_q <= in_base;
          res_q  <= '0;
        end
      end
      S_CALC: begin
        lat_q <= diff[62:0];
      end
      S_BIN: begin
        bucket_q   <= bucket;
        cnt_addr_q <= base_q + AW'(bucket);
      end
      S_CNT: begin
        res_q.accepted     <= 1'b1;
        res_q.bucket_index <= 5'(bucket_q);
        res_q.latency_ns   <= lat_q;
        res_q.read_value   <= '0;
      end
      S_RVAL: begin
        res_q.read_value <= rdata_q;
      end
      S_OUT: begin
        if (out_free) begin
          out_q <= res_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/l2h_bucket.sv -----
module l2h_bucket #(
  parameter int unsigned MAX_SLOT = 30,
  parameter int unsigned BW       = 5
) (
  input  logic [62:0]   latency_i,
  output logic [BW-1:0] bucket_o
);
  import l2h_pkg::*;

  logic [62:0] minus_one;
  logic [5:0]  bit_len;

  // ceil(log2(v)) is the bit length of v - 1
  always_comb begin
    minus_one = latency_i - 63'd1;
    bit_len   = '0;
    for (int i = 0; i < 63; i++) begin
      if (minus_one[i]) begin
        bit_len = 6'(i + 1);
      end
    end
    if (latency_i <= 63'd1) begin
      bucket_o = '0;
    end else if (32'(bit_len) > MAX_SLOT) begin
      bucket_o = BW'(MAX_SLOT);
    end else begin
      bucket_o = BW'(bit_len);
    end
  end

endmodule

// ----- rtl/l2h_checker.sv -----
module l2h_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input l2h_pkg::rsp_t out_rsp_o
);
  import l2h_pkg::*;

  // the counter sweep holds off input during reset
  a_no_input_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready_o)
    else $error("input ready during reset");

  // one item in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer while an item is in flight");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.accepted |->
      out_rsp_o.latency_ns == '0 && out_rsp_o.bucket_index == '0)
    else $error("unaccepted result carries latency or bucket");

  a_record_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.accepted |-> out_rsp_o.read_value == '0)
    else $error("record result carries a read value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

endmodule

bind log2_latency_histogram l2h_checker u_l2h_checker (.*);
